// ----- rtl/core/blr_pkg.sv -----
// Shared types and constants for the Bresenham line rasterizer.
package blr_pkg;

    localparam int COORD_W        = 6;
    localparam int ARGB_W         = 32;
    localparam int COORD_BITS_DEF = 6;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [ARGB_W-1:0]  argb;
    } t_line_cmd;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [ARGB_W-1:0]  pixel_argb;
        logic               last;
    } t_pixel;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fin;
    } t_dp_status;

endpackage

// ----- rtl/core/blr_datapath.sv -----
// Line setup and per-pixel Bresenham stepping registers.
module blr_datapath #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  blr_pkg::t_line_cmd i_line,
    input  blr_pkg::t_dp_cmd   i_cmd,
    output blr_pkg::t_dp_status o_status,
    output blr_pkg::t_pixel    o_pixel
);
    import blr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    logic [CB-1:0] x0, y0, x1, y1;
    logic [CB-1:0] adx, ady;
    logic          ymajor;
    logic [CB-1:0] sel_maj0, sel_maj1, sel_min0, sel_min1;
    logic [CB-1:0] maj0, maj1, min0, min1;
    logic [CB-1:0] len_b, len_a;
    logic [EW-1:0] a2, b2;

    logic          r_ymajor, n_ymajor;
    logic [CB-1:0] r_maj, n_maj;
    logic [CB-1:0] r_mnr, n_mnr;
    logic [CB-1:0] r_maj_end, n_maj_end;
    logic          r_dir_neg, n_dir_neg;
    logic [EW-1:0] r_err, n_err;
    logic [EW-1:0] r_inc_a, n_inc_a;
    logic [EW-1:0] r_inc_ab, n_inc_ab;
    logic [ARGB_W-1:0] r_argb, n_argb;

    logic          err_pos;
    logic [CB-1:0] px, py;

    // setup from the incoming command
    always_comb begin
        x0  = i_line.start_x[CB-1:0];
        y0  = i_line.start_y[CB-1:0];
        x1  = i_line.end_x[CB-1:0];
        y1  = i_line.end_y[CB-1:0];
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        ymajor = (ady >= adx);
        if (ymajor) begin
            sel_maj0 = y0; sel_maj1 = y1; sel_min0 = x0; sel_min1 = x1;
        end else begin
            sel_maj0 = x0; sel_maj1 = x1; sel_min0 = y0; sel_min1 = y1;
        end
        // reversed endpoints: swap so the major coordinate rises
        if (sel_maj1 < sel_maj0) begin
            maj0 = sel_maj1; maj1 = sel_maj0; min0 = sel_min1; min1 = sel_min0;
        end else begin
            maj0 = sel_maj0; maj1 = sel_maj1; min0 = sel_min0; min1 = sel_min1;
        end
        len_b = maj1 - maj0;
        len_a = (min1 > min0) ? min1 - min0 : min0 - min1;
        a2    = {2'b00, len_a, 1'b0};
        b2    = {2'b00, len_b, 1'b0};
    end

    assign err_pos = !r_err[EW-1] && (r_err != '0);

    always_comb begin
        n_ymajor  = r_ymajor;
        n_maj     = r_maj;
        n_mnr     = r_mnr;
        n_maj_end = r_maj_end;
        n_dir_neg = r_dir_neg;
        n_err     = r_err;
        n_inc_a   = r_inc_a;
        n_inc_ab  = r_inc_ab;
        n_argb    = r_argb;
        if (i_cmd.load) begin
            n_ymajor  = ymajor;
            n_maj     = maj0;
            n_mnr     = min0;
            n_maj_end = maj1;
            n_dir_neg = (min1 < min0);
            n_err     = a2 - {3'b000, len_b};
            n_inc_a   = a2;
            n_inc_ab  = a2 - b2;
            n_argb    = i_line.argb;
        end else if (i_cmd.step) begin
            n_maj = r_maj + 1'b1;
            if (err_pos) begin
                n_mnr = r_dir_neg ? r_mnr - 1'b1 : r_mnr + 1'b1;
                n_err = r_err + r_inc_ab;
            end else begin
                n_err = r_err + r_inc_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ymajor  <= n_ymajor;
        r_maj     <= n_maj;
        r_mnr     <= n_mnr;
        r_maj_end <= n_maj_end;
        r_dir_neg <= n_dir_neg;
        r_err     <= n_err;
        r_inc_a   <= n_inc_a;
        r_inc_ab  <= n_inc_ab;
        r_argb    <= n_argb;
    end

    assign px = r_ymajor ? r_mnr : r_maj;
    assign py = r_ymajor ? r_maj : r_mnr;

    assign o_status.fin       = (r_maj == r_maj_end);
    assign o_pixel.pixel_x    = COORD_W'(px);
    assign o_pixel.pixel_y    = COORD_W'(py);
    assign o_pixel.pixel_argb = r_argb;
    assign o_pixel.last       = o_status.fin;

endmodule

// ----- rtl/core/blr_controller.sv -----
// Handshake controller: loads a line, steps it per pixel transfer.
module blr_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  blr_pkg::t_dp_status i_status,
    output blr_pkg::t_dp_cmd    o_cmd
);
    import blr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   in_xfer, out_xfer, done_xfer;

    assign out_xfer  = (r_state == S_RUN) && !i_out_stall;
    assign done_xfer = out_xfer && i_status.fin;
    // next line may load in the cycle its predecessor's last pixel leaves
    assign o_in_stall  = (r_state == S_RUN) && !done_xfer;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_RUN);

    assign o_cmd.load = in_xfer;
    assign o_cmd.step = out_xfer && !i_status.fin;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_RUN;
            end
            S_RUN: begin
                if (done_xfer && !in_xfer) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------
//   in      | input     | i_in_valid / o_in_stall   | i_in_cmd  (t_line_cmd)
//   out     | output    | o_out_valid / i_out_stall | o_out_pix (t_pixel)
//
// A line of N pixels (N = major delta + 1, at most 2**COORD_BITS) is set up at
// its input transfer; its first pixel is presented the next cycle and the stepper
// advances once per pixel transfer, so a line holds the block until its last
// pixel transfers, and the next line is accepted in the cycle of that transfer. A
// stall on the output holds the pixel and freezes the stepper. Synchronous
// active-low reset returns the controller to idle; datapath registers are not reset.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  blr_pkg::t_line_cmd i_in_cmd,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output blr_pkg::t_pixel    o_out_pix
);
    import blr_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    blr_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    blr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_line   (i_in_cmd),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_pixel  (o_out_pix)
    );

endmodule
